FILE: hw/rtl/nsfc_pkg.sv
// Shared constants, result type and hex decode for the NMEA sentence framer.
package nsfc_pkg;

  // Default line buffer size in bytes
  localparam int LINE_BUF_BYTES_DEF = 128;

  // Fixed field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  // Framing characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

  // Number of checksum digits after the star
  localparam logic [1:0] SUM_DIGITS = 2'd2;

  // One finished sentence
  typedef struct packed {
    logic              sentence_valid;
    logic [BYTE_W-1:0] computed_sum;
    logic [BYTE_W-1:0] received_sum;
    logic [LEN_W-1:0]  line_length;
  } nsfc_res_t;

  // Decode one hex digit of either case; bit 4 set marks a non-hex byte
  function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
    logic [4:0] n;
    n = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      n = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      n = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      n = {1'b0, 4'(c - 8'h57)};
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/nsfc_in_reg.sv
// Input word register in front of the framer.
module nsfc_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      in_valid,
  input  logic [nsfc_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                      byte_vld,
  output logic [nsfc_pkg::BYTE_W-1:0] byte_dat
);
  import nsfc_pkg::*;

  logic              vld_r;
  logic [BYTE_W-1:0] dat_r;

  // Capture a word whenever the pipeline moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      dat_r <= in_rx_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_dat = dat_r;

endmodule

FILE: hw/rtl/nsfc_framer.sv
// Line framing state and checksum accumulation, one byte per cycle while advance is high.
module nsfc_framer #(
  parameter int LINE_BUF_BYTES = nsfc_pkg::LINE_BUF_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        byte_vld,
  input  logic [nsfc_pkg::BYTE_W-1:0] byte_dat,
  output logic                        res_vld,
  output nsfc_pkg::nsfc_res_t         res
);
  import nsfc_pkg::*;

  localparam int CNT_W     = $clog2(LINE_BUF_BYTES);
  localparam int LEN_EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_BUF_BYTES - 1);

  logic              in_line_r,   in_line_nxt;
  logic [CNT_W-1:0]  cnt_r,       cnt_nxt;
  logic [BYTE_W-1:0] sum_r,       sum_nxt;
  logic              star_r,      star_nxt;
  logic [1:0]        dcnt_r,      dcnt_nxt;
  logic [BYTE_W-1:0] dval_r,      dval_nxt;
  logic              bad_r,       bad_nxt;

  logic [4:0]           nib;
  logic                 digits_ok;
  logic [LEN_EXT_W-1:0] cnt_ext;

  assign nib       = hex_nibble(byte_dat);
  assign digits_ok = star_r && (dcnt_r == SUM_DIGITS) && !bad_r;
  assign cnt_ext   = LEN_EXT_W'(cnt_r);

  // Next line state and result for the current word
  always_comb begin
    in_line_nxt = in_line_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    star_nxt    = star_r;
    dcnt_nxt    = dcnt_r;
    dval_nxt    = dval_r;
    bad_nxt     = bad_r;
    res_vld     = 1'b0;
    res.sentence_valid = digits_ok && (sum_r == dval_r);
    res.computed_sum   = sum_r;
    res.received_sum   = digits_ok ? dval_r : '0;
    res.line_length    = cnt_ext[LEN_W-1:0];

    if (byte_vld) begin
      if (byte_dat == CH_DOLLAR) begin
        // Restart the line on every dollar
        in_line_nxt = 1'b1;
        cnt_nxt     = CNT_W'(1);
        sum_nxt     = '0;
        star_nxt    = 1'b0;
        dcnt_nxt    = '0;
        dval_nxt    = '0;
        bad_nxt     = 1'b0;
      end else if (in_line_r && byte_dat != CH_CR) begin
        if (byte_dat == CH_LF || cnt_r >= CNT_MAX) begin
          // Emit at line feed, drop silently on overflow
          res_vld     = (byte_dat == CH_LF);
          in_line_nxt = 1'b0;
          cnt_nxt     = '0;
          sum_nxt     = '0;
          star_nxt    = 1'b0;
          dcnt_nxt    = '0;
          dval_nxt    = '0;
          bad_nxt     = 1'b0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (!star_r) begin
            if (byte_dat == CH_STAR) begin
              star_nxt = 1'b1;
            end else begin
              if (byte_dat == CH_NUL) begin
                bad_nxt = 1'b1;
              end
              sum_nxt = sum_r ^ byte_dat;
            end
          end else if (dcnt_r < SUM_DIGITS) begin
            // Shift in one checksum digit
            if (nib[4]) begin
              bad_nxt = 1'b1;
            end
            dval_nxt = {dval_r[3:0], (nib[4] ? 4'h0 : nib[3:0])};
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end
      end
    end
  end

  // Hold line state between words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_line_r <= 1'b0;
      cnt_r     <= '0;
      sum_r     <= '0;
      star_r    <= 1'b0;
      dcnt_r    <= '0;
      dval_r    <= '0;
      bad_r     <= 1'b0;
    end else if (advance) begin
      in_line_r <= in_line_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      star_r    <= star_nxt;
      dcnt_r    <= dcnt_nxt;
      dval_r    <= dval_nxt;
      bad_r     <= bad_nxt;
    end
  end

endmodule

FILE: hw/rtl/nsfc_out_reg.sv
// Result register on the output channel.
module nsfc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                res_vld,
  input  nsfc_pkg::nsfc_res_t res,
  output logic                out_valid,
  output nsfc_pkg::nsfc_res_t out_res
);
  import nsfc_pkg::*;

  logic      vld_r;
  nsfc_res_t res_r;

  // Load a new result when the pipeline moves, hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

FILE: hw/rtl/nmea_sentence_framer_checksum_top.sv
// Top level of the NMEA sentence framer and checksum checker.
// Path: a line feed word goes through the input register, then the framer logic
// into the result register; a stall holds every stage in place.
// Throughput: one word per cycle; the input is stalled only while a result
// waits in the result register and the output is stalled.
// Reset: synchronous active-low rst_n empties both registers and returns the
// framer to waiting for a dollar sign.
module nmea_sentence_framer_checksum_top #(
  parameter int LINE_BUF_BYTES = nsfc_pkg::LINE_BUF_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nsfc_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_sentence_valid,
  output logic [nsfc_pkg::BYTE_W-1:0] out_computed_sum,
  output logic [nsfc_pkg::BYTE_W-1:0] out_received_sum,
  output logic [nsfc_pkg::LEN_W-1:0]  out_line_length
);
  import nsfc_pkg::*;

  logic              advance;
  logic              byte_vld;
  logic [BYTE_W-1:0] byte_dat;
  logic              res_vld;
  nsfc_res_t         res;
  nsfc_res_t         out_res;

  // Move the whole pipeline unless a held result is stalled
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  nsfc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .byte_vld   (byte_vld),
    .byte_dat   (byte_dat)
  );

  nsfc_framer #(
    .LINE_BUF_BYTES (LINE_BUF_BYTES)
  ) u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .byte_vld (byte_vld),
    .byte_dat (byte_dat),
    .res_vld  (res_vld),
    .res      (res)
  );

  nsfc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_vld   (res_vld),
    .res       (res),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_sentence_valid = out_res.sentence_valid;
  assign out_computed_sum   = out_res.computed_sum;
  assign out_received_sum   = out_res.received_sum;
  assign out_line_length    = out_res.line_length;

endmodule

FILE: hw/rtl/nsfc_checker.sv
// Port-level checker for the NMEA sentence framer, bound to the top level.
module nsfc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [nsfc_pkg::BYTE_W-1:0] in_rx_byte,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_sentence_valid,
  input logic [nsfc_pkg::BYTE_W-1:0] out_computed_sum,
  input logic [nsfc_pkg::BYTE_W-1:0] out_received_sum,
  input logic [nsfc_pkg::LEN_W-1:0]  out_line_length
);
  import nsfc_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A stalled result word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word withdrawn while stalled");

  // A stalled result word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_sentence_valid, out_computed_sum,
                                        out_received_sum, out_line_length}))
    else $error("result word changed while stalled");

  // A good sentence always carries matching sums
  a_valid_sums: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_valid |-> out_computed_sum == out_received_sum)
    else $error("good sentence with mismatched checksum");

  // Only a line feed word produces a result
  a_lf_only: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_rx_byte != CH_LF) ##1 !in_stall |=> !out_valid)
    else $error("result word without a line feed");

endmodule

bind nmea_sentence_framer_checksum_top nsfc_checker u_nsfc_checker (.*);
